// File: sv/brb_pkg.sv
`default_nettype none

package brb_pkg;

    // Width of counts, capacity and free space.
    localparam int CNT_W = 7;
    localparam int DATA_W = 8;

    // Depth of the command queue between the front and the back.
    localparam int QDEPTH = 2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE_DONE = 2'd0,
        KIND_READ_BYTE  = 2'd1,
        KIND_READ_NONE  = 2'd2
    } resp_kind_t;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] data_byte;
        logic              burst_last;
        logic [CNT_W-1:0]  read_count;
    } req_t;

    typedef struct packed {
        resp_kind_t        resp_kind;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  byte_total;
        logic              run_last;
        logic [CNT_W-1:0]  free_space;
        logic              is_empty;
    } resp_t;

endpackage

`default_nettype wire

// File: sv/brb_front.sv
`default_nettype none

module brb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire brb_pkg::req_t req,
    output logic               busy,
    output logic               cmd_valid,
    output brb_pkg::req_t      cmd,
    input  wire logic          cmd_pop
);
    import brb_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    req_t            queue_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign busy      = (count_reg == CW'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign push      = start && !busy;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= req;
        end
    end

endmodule

`default_nettype wire

// File: sv/brb_back.sv
`default_nettype none

module brb_back #(
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [brb_pkg::CNT_W-1:0]  cfg_data,
    input  wire logic                       cmd_valid,
    input  wire brb_pkg::req_t              cmd,
    output logic                            cmd_pop,
    output logic                            result_valid,
    output brb_pkg::resp_t                  result
);
    import brb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       rp_reg, rp_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    burst_reg, burst_next;
    logic [CNT_W-1:0]    cap_reg, cap_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [CNT_W-1:0]    total_reg, total_next;

    logic                out_valid_reg, out_valid_next;
    resp_kind_t          out_kind_reg, out_kind_next;
    logic [CNT_W-1:0]    out_total_reg, out_total_next;
    logic                out_last_reg, out_last_next;
    logic [CNT_W-1:0]    out_free_reg, out_free_next;
    logic                out_empty_reg, out_empty_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rdata_reg;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_wa;

    logic [SUM_W-1:0]    wp_sum;
    logic [SUM_W-1:0]    wp_wrap;
    logic [CNT_W-1:0]    rp_plus;
    logic [CNT_W-1:0]    occ_dec;
    logic [CNT_W-1:0]    read_n;
    logic [CNT_W-1:0]    cfg_clamped;

    // Write slot is the one after the newest byte, folded into the ring.
    assign wp_sum  = SUM_W'(rp_reg) + SUM_W'(occ_reg);
    assign wp_wrap = (wp_sum >= SUM_W'(cap_reg)) ? (wp_sum - SUM_W'(cap_reg)) : wp_sum;
    assign mem_wa  = wp_wrap[AW-1:0];
    assign rp_plus = CNT_W'(rp_reg) + 1'b1;
    assign occ_dec = occ_reg - 1'b1;
    assign read_n  = (cmd.read_count < occ_reg) ? cmd.read_count : occ_reg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = CNT_W'(1);
        end
        else if (cfg_data > DEPTH_C)
        begin
            cfg_clamped = DEPTH_C;
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    // A capacity write takes the idle cycle, so a waiting command stays queued.
    assign cmd_pop = (state_reg == ST_IDLE) && !cfg_we;

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        occ_next       = occ_reg;
        burst_next     = burst_reg;
        cap_next       = cap_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        out_valid_next = 1'b0;
        out_kind_next  = out_kind_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;
        out_free_next  = out_free_reg;
        out_empty_next = out_empty_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    cap_next = cfg_clamped;
                    rp_next  = '0;
                    occ_next = '0;
                end
                else if (cmd_valid && cmd.req_type == REQ_WRITE)
                begin
                    if (occ_reg < cap_reg)
                    begin
                        mem_we   = 1'b1;
                        occ_next = occ_reg + 1'b1;
                        if (burst_reg != '1)
                        begin
                            burst_next = burst_reg + 1'b1;
                        end
                    end
                    if (cmd.burst_last)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_WRITE_DONE;
                        out_total_next = burst_next;
                        out_last_next  = 1'b1;
                        out_free_next  = cap_reg - occ_next;
                        out_empty_next = (occ_next == '0);
                        burst_next     = '0;
                    end
                end
                else if (cmd_valid)
                begin
                    if (read_n == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_READ_NONE;
                        out_total_next = '0;
                        out_last_next  = 1'b1;
                        out_free_next  = cap_reg - occ_reg;
                        out_empty_next = (occ_reg == '0);
                    end
                    else
                    begin
                        remain_next = read_n;
                        total_next  = '0;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // One byte leaves the ring per cycle; its data shows up in the next cycle
                // together with the status captured here.
                mem_re         = 1'b1;
                rp_next        = (rp_plus >= cap_reg) ? '0 : rp_plus[AW-1:0];
                occ_next       = occ_dec;
                total_next     = total_reg + 1'b1;
                remain_next    = remain_reg - 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_READ_BYTE;
                out_total_next = total_reg + 1'b1;
                out_last_next  = (remain_reg == CNT_W'(1));
                out_free_next  = cap_reg - occ_dec;
                out_empty_next = (occ_dec == '0);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            occ_reg       <= '0;
            burst_reg     <= '0;
            cap_reg       <= DEPTH_C;
            remain_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            occ_reg       <= occ_next;
            burst_reg     <= burst_next;
            cap_reg       <= cap_next;
            remain_reg    <= remain_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
        out_free_reg  <= out_free_next;
        out_empty_reg <= out_empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= cmd.data_byte;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rp_reg];
        end
    end

    assign result_valid      = out_valid_reg;
    assign result.resp_kind  = out_kind_reg;
    assign result.read_data  = (out_kind_reg == KIND_READ_BYTE) ? rdata_reg : '0;
    assign result.byte_total = out_total_reg;
    assign result.run_last   = out_last_reg;
    assign result.free_space = out_free_reg;
    assign result.is_empty   = out_empty_reg;

endmodule

`default_nettype wire

// File: sv/byte_ring_buffer_core.sv
`default_nettype none

// Byte ring buffer with a programmable capacity.
// A command is taken on a rising edge with start high and busy low. A write
// command stores data_byte while there is room; the command with burst_last
// set produces one transfer on result with the count of stored bytes. A read
// command produces one transfer per byte, oldest first, with run_last on the
// final one, or a single empty-read transfer when nothing can be read.
// Each transfer is held on result for exactly one cycle with result_valid high;
// the receiver cannot stall it. Commands pass through a two-entry queue, so
// busy rises only when that queue is full.
// A taken command is registered in the queue, then popped by the back while idle,
// which registers a burst-done or empty-read result; a read first enters the read
// state, which registers each byte with its status. Write commands run at one per
// cycle while no read runs and cfg_we is low. A read holds the execution side until
// its final byte (one byte per cycle from the single memory read port).
// Writing cfg_data with cfg_we sets the capacity (0 acts as 1, values above
// DEPTH act as DEPTH) and empties the ring; write it only while idle.
// After reset the ring is empty and the capacity is DEPTH.
module byte_ring_buffer_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire brb_pkg::req_t              req,
    output logic                            busy,
    input  wire logic                       cfg_we,
    input  wire logic [brb_pkg::CNT_W-1:0]  cfg_data,
    output logic                            result_valid,
    output brb_pkg::resp_t                  result
);
    import brb_pkg::*;

    logic  cmd_valid;
    logic  cmd_pop;
    req_t  cmd;

    brb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // Only a read byte can be followed by more transfers of the same command.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.resp_kind != KIND_READ_BYTE |-> result.run_last)
        else $error("non-read result without run_last");

    // A read run continues in the next cycle with the count one higher.
    a_read_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.resp_kind == KIND_READ_BYTE && !result.run_last
        |=> result_valid && result.resp_kind == KIND_READ_BYTE
            && result.byte_total == $past(result.byte_total) + 1'b1)
        else $error("read run broken");

    // An empty ring always has at least one free slot.
    a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_empty |-> result.free_space != '0)
        else $error("empty ring reports no free space");

    // Only read-byte transfers carry data.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.resp_kind != KIND_READ_BYTE |-> result.read_data == '0)
        else $error("data on a non-read result");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import brb_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT = 400;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_data;
    logic result_valid;
    resp_t result;

    // Predicted ring contents and pointers.
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    int head_ptr = 0;
    int fill_level = 0;
    int burst_count = 0;
    logic [CNT_W-1:0] cap_setting = CNT_W'(RING_DEPTH);

    resp_t pending_resps [$];
    int max_gap = 14;
    int n_errors = 0;
    int n_commands = 0;
    int n_results = 0;
    int n_cap_writes = 0;
    int stall_cycles = 0;

    always #10 clk = ~clk;

    byte_ring_buffer_core #(
        .DEPTH(RING_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .result(result)
    );

    function automatic int live_capacity();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > RING_DEPTH)
            return RING_DEPTH;
        return int'(cap_setting);
    endfunction

    task automatic push_resp(input resp_kind_t kind, input logic [DATA_W-1:0] data,
                             input int total, input logic last);
        resp_t r;
        r.resp_kind = kind;
        r.read_data = data;
        r.byte_total = CNT_W'(total);
        r.run_last = last;
        r.free_space = CNT_W'(live_capacity() - fill_level);
        r.is_empty = (fill_level == 0);
        pending_resps.push_back(r);
    endtask

    task automatic predict_ring_cmd(input req_t c);
        int cap;
        int slot;
        int n;
        cap = live_capacity();
        if (c.req_type == REQ_WRITE) begin
            if (fill_level < cap) begin
                slot = head_ptr + fill_level;
                if (slot >= cap)
                    slot -= cap;
                ring_mem[slot] = c.data_byte;
                fill_level++;
                if (burst_count < 127)
                    burst_count++;
            end
            if (c.burst_last) begin
                push_resp(KIND_WRITE_DONE, '0, burst_count, 1'b1);
                burst_count = 0;
            end
        end else begin
            n = (int'(c.read_count) < fill_level) ? int'(c.read_count) : fill_level;
            if (n == 0)
                push_resp(KIND_READ_NONE, '0, 0, 1'b1);
            for (int k = 0; k < n; k++) begin
                slot = head_ptr;
                head_ptr++;
                if (head_ptr >= cap)
                    head_ptr = 0;
                fill_level--;
                push_resp(KIND_READ_BYTE, ring_mem[slot], k + 1, k + 1 == n);
            end
        end
    endtask

    function automatic req_t make_write(input logic [DATA_W-1:0] data, input logic last);
        req_t c;
        c.req_type = REQ_WRITE;
        c.data_byte = data;
        c.burst_last = last;
        c.read_count = CNT_W'($urandom);
        return c;
    endfunction

    function automatic req_t make_read(input logic [CNT_W-1:0] count);
        req_t c;
        c.req_type = REQ_READ;
        c.data_byte = DATA_W'($urandom);
        c.burst_last = 1'($urandom);
        c.read_count = count;
        return c;
    endfunction

    // Mostly short reads, now and then an oversized or a full-depth one.
    function automatic logic [CNT_W-1:0] random_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            return CNT_W'($urandom_range(0, 8));
        if (pick == 8)
            return CNT_W'($urandom_range(0, 127));
        return CNT_W'(RING_DEPTH);
    endfunction

    // Called at a rising edge. Start is left high after the transfer when no
    // gap follows, so the next call can keep it asserted.
    task automatic send_cmd(input req_t c);
        int gap;
        start <= 1'b1;
        req <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_ring_cmd(c);
        n_commands++;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_resps.size() != 0)
            @(posedge clk);
        // Non-final writes leave no result behind, so let the pipeline empty.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_setting = value;
        head_ptr = 0;
        fill_level = 0;
        n_cap_writes++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin
        resp_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1) begin
            n_results++;
            if (pending_resps.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, result);
                n_errors++;
            end else begin
                want = pending_resps.pop_front();
                check_field("resp_kind", want.resp_kind, result.resp_kind);
                check_field("read_data", want.read_data, result.read_data);
                check_field("byte_total", want.byte_total, result.byte_total);
                check_field("run_last", want.run_last, result.run_last);
                check_field("free_space", want.free_space, result.free_space);
                check_field("is_empty", want.is_empty, result.is_empty);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || result_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic test_empty_reads();
        send_cmd(make_read(CNT_W'(0)));
        send_cmd(make_read(CNT_W'(RING_DEPTH)));
        send_cmd(make_read(CNT_W'(127)));
    endtask

    task automatic test_short_bursts();
        send_cmd(make_write(8'h00, 1'b1));
        send_cmd(make_write(8'hFF, 1'b1));
        send_cmd(make_read(CNT_W'(1)));
        send_cmd(make_read(CNT_W'(127)));
        send_cmd(make_write(8'hA5, 1'b0));
        send_cmd(make_write(8'h5A, 1'b0));
        send_cmd(make_write(8'h80, 1'b1));
        // A zero count reports nothing found even with bytes stored.
        send_cmd(make_read(CNT_W'(0)));
        send_cmd(make_read(CNT_W'(2)));
        send_cmd(make_read(CNT_W'(5)));
    endtask

    task automatic test_capacity_extremes();
        // Zero acts as a single slot: the last two bytes are dropped.
        write_capacity(CNT_W'(0));
        send_cmd(make_write(8'h11, 1'b0));
        send_cmd(make_write(8'h22, 1'b0));
        send_cmd(make_write(8'h33, 1'b1));
        send_cmd(make_read(CNT_W'(RING_DEPTH)));
        write_capacity(CNT_W'(127));
        send_cmd(make_write(8'h7E, 1'b1));
        send_cmd(make_read(CNT_W'(1)));
        // Three slots, with the second burst wrapping past the end.
        write_capacity(CNT_W'(3));
        send_cmd(make_write(8'h01, 1'b0));
        send_cmd(make_write(8'h02, 1'b0));
        send_cmd(make_write(8'h03, 1'b1));
        send_cmd(make_read(CNT_W'(2)));
        send_cmd(make_write(8'hFE, 1'b0));
        send_cmd(make_write(8'hFD, 1'b1));
        send_cmd(make_read(CNT_W'(3)));
    endtask

    // More than 127 bytes accepted in one burst, made possible by reads in between.
    task automatic test_long_burst();
        write_capacity(CNT_W'(RING_DEPTH));
        for (int i = 1; i <= 130; i++) begin
            send_cmd(make_write(DATA_W'($urandom), i == 130));
            if (i % 45 == 0)
                send_cmd(make_read(CNT_W'($urandom_range(45, 127))));
        end
        send_cmd(make_read(CNT_W'(127)));
    endtask

    task automatic test_random_traffic();
        logic [CNT_W-1:0] caps [5];
        int sent;
        int blen;
        bit paused;
        caps[0] = CNT_W'(1);
        caps[1] = CNT_W'(2);
        caps[2] = CNT_W'($urandom_range(3, 63));
        caps[3] = CNT_W'(RING_DEPTH);
        caps[4] = CNT_W'($urandom_range(1, 127));
        paused = 1'b0;
        for (int p = 0; p < 5; p++) begin
            write_capacity(caps[p]);
            max_gap = (p % 2 == 0) ? 0 : 14;
            sent = 0;
            while (sent < 24) begin
                if ($urandom_range(0, 9) < 6) begin
                    if ($urandom_range(0, 4) == 0)
                        blen = $urandom_range(1, live_capacity() + 3);
                    else
                        blen = $urandom_range(1, 4);
                    for (int b = 1; b <= blen; b++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            send_cmd(make_read(random_count()));
                            sent++;
                        end
                        send_cmd(make_write(DATA_W'($urandom), b == blen));
                        sent++;
                    end
                end else begin
                    send_cmd(make_read(random_count()));
                    sent++;
                end
                if (p == 2 && sent >= 12 && !paused) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        start <= 1'b0;
        req <= '0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_short_bursts();
        test_capacity_extremes();
        test_long_burst();
        test_random_traffic();
        wait_drained();

        if (pending_resps.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_resps.size());
            n_errors++;
        end
        $display("Sent %0d commands and checked %0d result transfers across %0d capacity writes,",
                 n_commands, n_results, n_cap_writes);
        $display("including full-ring drops, wrap-around, clamped reads and count saturation.");
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
